// ===== rtl/swps_pkg.sv =====
// Shared types and codes for the stop-and-wait priority sender.
`timescale 1ns / 1ps
`default_nettype none
package swps_pkg;

  // Operation codes carried on the input side
  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_CONFIRM = 2'd1,
    OP_RESET   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_QUEUED       = 3'd1,
    ST_DISCONNECTED = 3'd2,
    ST_UNKNOWN      = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  // Register indexes (paddr[2])
  localparam logic REG_PONG = 1'b0;
  localparam logic REG_TILE = 1'b1;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned PRIO_W = 2;
  localparam int unsigned CNT_W  = 5;

  // One queued message
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TYPE_W-1:0] msg_type;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Command broadcast to every queue cell
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t entry;
  } qcmd_t;

endpackage
`default_nettype wire

// ===== rtl/swps_cell.sv =====
// One cell of the sorted shift-register priority queue.
`timescale 1ns / 1ps
`default_nettype none
module swps_cell (
  input  wire logic            clk,
  input  wire swps_pkg::qcmd_t cmd,
  input  wire logic            occupied,
  input  wire logic            stay_prev,
  input  wire swps_pkg::entry_t prev_entry,
  input  wire swps_pkg::entry_t next_entry,
  output logic                 stay,
  output swps_pkg::entry_t     entry
);
  import swps_pkg::*;

  // Entry keeps its place on insert when it ranks at or ahead of the new one
  assign stay = occupied && (entry.prio <= cmd.entry.prio);

  // Pop shifts towards the head; insert shifts away from it past the slot
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      entry <= next_entry;
    end else if (cmd.insert && !stay) begin
      entry <= stay_prev ? cmd.entry : prev_entry;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swps_queue.sv =====
// Priority queue built as a chain of cells, with its occupancy counter.
`timescale 1ns / 1ps
`default_nettype none
module swps_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire swps_pkg::qcmd_t                    cmd,
  input  wire logic                               clear,
  output swps_pkg::entry_t                        head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        count,
  output logic                                    full
);
  import swps_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  entry_t entries [QUEUE_DEPTH];
  logic   stays   [QUEUE_DEPTH];

  // Chain of cells; cell 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   sp;
    entry_t pe;
    entry_t ne;

    assign occ = (CW'(i) < count);

    if (i == 0) begin : g_first
      assign sp = 1'b1;
      assign pe = cmd.entry;
    end else begin : g_mid
      assign sp = stays[i-1];
      assign pe = entries[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ne = cmd.entry;
    end else begin : g_inner
      assign ne = entries[i+1];
    end

    swps_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .stay_prev  (sp),
      .prev_entry (pe),
      .next_entry (ne),
      .stay       (stays[i]),
      .entry      (entries[i])
    );
  end

  assign head = entries[0];
  assign full = (count == CW'(QUEUE_DEPTH));

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stop_and_wait_priority_sender_top.sv =====
// Top level of the stop-and-wait priority sender.
`timescale 1ns / 1ps
`default_nettype none
// Stop-and-wait message scheduler. A request is taken on s_tvalid & s_tready and
// its result is shown on the master side from the next cycle, held until taken;
// a new request is taken every cycle while the result register is free or being
// drained, so the block sustains one request per cycle. Queued messages sit in a
// chain of QUEUE_DEPTH cells kept sorted by priority (oldest first among equals):
// an insert or a pop completes in the cycle of the request, the cells
// shifting in parallel, and the head cell always holds the next message to send.
// There is no clearing pass after reset. Queue entries need no reset as only the
// occupied cells are ever read.
module stop_and_wait_priority_sender_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // msg_type[7:0], priority_req[9:8], link_connected[10]
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // tx_sequence[31:0], tx_type[39:32], status[42:40],
                                      // awaiting[43], queued_count[48:44]
  output logic [0:0]       m_tuser,   // tx_valid[0]
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import swps_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [TYPE_W-1:0] pong_code;
  logic [TYPE_W-1:0] tile_code;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pong_code <= TYPE_W'(1);
      tile_code <= TYPE_W'(2);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_PONG) begin
        pong_code <= pwdata[TYPE_W-1:0];
      end else begin
        tile_code <= pwdata[TYPE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PONG) begin
      prdata[TYPE_W-1:0] = pong_code;
    end else begin
      prdata[TYPE_W-1:0] = tile_code;
    end
  end

  // Request fields
  op_t               op;
  logic [TYPE_W-1:0] in_type;
  logic [PRIO_W-1:0] in_prio;
  logic              in_link;
  logic              accept;

  assign op      = op_t'(s_tuser);
  assign in_type = s_tdata[7:0];
  assign in_prio = s_tdata[9:8];
  assign in_link = s_tdata[10];
  assign accept  = s_tvalid && s_tready;

  // Core state
  logic [SEQ_W-1:0] seq_ctr;
  logic [SEQ_W-1:0] seq_ctr_next;
  logic             awaiting;
  logic             awaiting_next;

  // Queue
  qcmd_t        qcmd;
  logic         qclear;
  entry_t       head;
  logic [CW-1:0] count;
  logic         full;

  swps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (qcmd),
    .clear (qclear),
    .head  (head),
    .count (count),
    .full  (full)
  );

  // Result of the current request
  logic              res_tx;
  logic [SEQ_W-1:0]  res_seq;
  logic [TYPE_W-1:0] res_type;
  status_t           res_status;
  logic [CW-1:0]     res_count;

  always_comb begin
    seq_ctr_next   = seq_ctr;
    awaiting_next  = awaiting;
    qcmd.insert    = 1'b0;
    qcmd.pop       = 1'b0;
    qcmd.entry     = '{seq: seq_ctr + SEQ_W'(1), msg_type: in_type, prio: in_prio};
    qclear         = 1'b0;
    res_tx         = 1'b0;
    res_seq        = '0;
    res_type       = '0;
    res_status     = ST_OK;
    res_count      = count;
    if (accept) begin
      unique case (op)
        OP_SEND: begin
          if (!in_link) begin
            res_status = ST_DISCONNECTED;
          end else begin
            seq_ctr_next = seq_ctr + SEQ_W'(1);
            if (awaiting) begin
              if (!full) begin
                qcmd.insert = 1'b1;
                res_count   = count + CW'(1);
                res_status  = ST_QUEUED;
              end else begin
                res_status = ST_FULL;
              end
            end else if (in_type == pong_code || in_type == tile_code) begin
              res_tx        = 1'b1;
              res_seq       = seq_ctr_next;
              res_type      = in_type;
              awaiting_next = 1'b1;
            end else begin
              res_status = ST_UNKNOWN;
            end
          end
        end
        OP_CONFIRM: begin
          if (count != '0) begin
            qcmd.pop      = 1'b1;
            res_count     = count - CW'(1);
            res_tx        = 1'b1;
            res_seq       = head.seq;
            res_type      = head.msg_type;
            awaiting_next = 1'b1;
          end else begin
            awaiting_next = 1'b0;
          end
        end
        OP_RESET: begin
          qclear        = 1'b1;
          res_count     = '0;
          awaiting_next = 1'b0;
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_ctr  <= '0;
      awaiting <= 1'b0;
    end else begin
      seq_ctr  <= seq_ctr_next;
      awaiting <= awaiting_next;
    end
  end

  // Output register
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= res_tx;
      m_tdata <= {7'd0, CNT_W'(res_count), awaiting_next, res_status, res_type, res_seq};
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !awaiting |-> count == '0)
    else $error("messages queued while no confirmation outstanding");

  a_tx_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[42:40] == ST_OK)
    else $error("transmission reported with a failure status");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_CONFIRM && count != '0 |=> count == $past(count) - CW'(1))
    else $error("confirmation did not remove one queued message");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for the stop-and-wait priority sender: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;
  import swps_pkg::*;

  localparam int unsigned HOLD_DEPTH  = 16;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned NUM_PHASES  = 5;

  // One result as seen on the master side
  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_seq;
    logic [7:0]  tx_type;
    status_t     status;
    logic        awaiting;
    logic [4:0]  queued;
  } tx_report_t;

  // One request of the stimulus; fixed rows carry a hand-written result
  typedef struct {
    op_t        op;
    logic [7:0] mtype;
    logic [1:0] prio;
    logic       link;
    int         reps;
    bit         fixed;
    tx_report_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // msg_type[7:0], priority_req[9:8], link_connected[10]
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // tx_sequence[31:0], tx_type[39:32], status[42:40],
                               // awaiting[43], queued_count[48:44]
  logic [0:0]  m_tuser;        // tx_valid[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [7:0]  pong_code;
  logic [7:0]  tile_code;
  logic [31:0] seq_counter;
  logic        waiting;
  entry_t      held_msgs[$];

  tx_report_t  tx_reports_due[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  stop_and_wait_priority_sender_top #(.QUEUE_DEPTH(HOLD_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Scheduler prediction: stamps, queues, pops by priority (oldest first among equals)
  function automatic tx_report_t schedule_request(input op_t op, input logic [7:0] mtype,
                                                  input logic [1:0] prio, input logic link);
    tx_report_t r;
    entry_t     e;
    int         best;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_SEND: begin
        if (!link) begin
          r.status = ST_DISCONNECTED;
        end else begin
          seq_counter = seq_counter + 32'd1;
          if (waiting) begin
            if (held_msgs.size() < HOLD_DEPTH) begin
              e.seq = seq_counter;
              e.msg_type = mtype;
              e.prio = prio;
              held_msgs.insert(held_msgs.size(), e);
              r.status = ST_QUEUED;
            end else begin
              r.status = ST_FULL;
            end
          end else if (mtype == pong_code || mtype == tile_code) begin
            r.tx_valid = 1'b1;
            r.tx_seq = seq_counter;
            r.tx_type = mtype;
            waiting = 1'b1;
          end else begin
            r.status = ST_UNKNOWN;
          end
        end
      end
      OP_CONFIRM: begin
        if (held_msgs.size() > 0) begin
          best = 0;
          for (int i = 1; i < held_msgs.size(); i++)
            if (held_msgs[i].prio < held_msgs[best].prio) best = i;
          r.tx_valid = 1'b1;
          r.tx_seq = held_msgs[best].seq;
          r.tx_type = held_msgs[best].msg_type;
          held_msgs.delete(best);
          waiting = 1'b1;
        end else begin
          waiting = 1'b0;
        end
      end
      OP_RESET: begin
        held_msgs.delete();
        waiting = 1'b0;
      end
      default: ;
    endcase
    r.awaiting = waiting;
    r.queued = 5'(held_msgs.size());
    return r;
  endfunction

  function automatic tx_report_t txrep(input logic tx, input logic [31:0] seq,
                                       input logic [7:0] ty, input status_t st,
                                       input logic aw, input logic [4:0] cnt);
    tx_report_t r;
    r.tx_valid = tx;
    r.tx_seq = seq;
    r.tx_type = ty;
    r.status = st;
    r.awaiting = aw;
    r.queued = cnt;
    return r;
  endfunction

  task automatic add_row(input op_t op, input logic [7:0] mtype, input logic [1:0] prio,
                         input logic link, input int reps, input bit fixed,
                         input tx_report_t want);
    stim_row_t row;
    row.op = op;
    row.mtype = mtype;
    row.prio = prio;
    row.link = link;
    row.reps = reps;
    row.fixed = fixed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Random request: sends of known or random types, mostly connected, with confirms, resets and no-ops mixed in
  function automatic stim_row_t random_request(input int send_pct);
    stim_row_t row;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < send_pct) row.op = OP_SEND;
    else if (pick < 93) row.op = OP_CONFIRM;
    else if (pick < 97) row.op = OP_RESET;
    else row.op = OP_NOP;
    case ($urandom_range(0, 3))
      0: row.mtype = pong_code;
      1: row.mtype = tile_code;
      default: row.mtype = 8'($urandom_range(0, 255));
    endcase
    row.prio = 2'($urandom_range(0, 3));
    row.link = ($urandom_range(0, 9) != 0);
    row.reps = 1;
    row.fixed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Offer one request, with an occasional idle burst ahead of it
  task automatic put_request(input stim_row_t row);
    tx_report_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 14)) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.op;
    s_tdata  <= {5'b0, row.link, row.prio, row.mtype};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = schedule_request(row.op, row.mtype, row.prio, row.link);
    if (row.fixed) predicted = row.want;
    tx_reports_due.insert(tx_reports_due.size(), predicted);
  endtask

  // APB write of a type code, then read it back
  task automatic program_type_code(input logic reg_sel, input logic [7:0] code);
    logic [23:0] junk;
    junk = 24'($urandom());
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {junk, code};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_PONG) pong_code = code;
    else tile_code = code;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {24'h0, code}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readback reg %0d: exp 0x%08h got 0x%08h", reg_sel, {24'h0, code}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random stalls, one long hold on request
  always @(posedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest one due
  always @(posedge clk) begin
    tx_report_t seen;
    tx_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.tx_valid = m_tuser[0];
      seen.tx_seq   = m_tdata[31:0];
      seen.tx_type  = m_tdata[39:32];
      seen.status   = status_t'(m_tdata[42:40]);
      seen.awaiting = m_tdata[43];
      seen.queued   = m_tdata[48:44];
      if (tx_reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none due: tx %0b seq %0d type 0x%02h st %0d", $time,
                   seen.tx_valid, seen.tx_seq, seen.tx_type, seen.status);
      end else begin
        want = tx_reports_due.pop_front();
        if (seen.tx_valid !== want.tx_valid || seen.tx_seq !== want.tx_seq ||
            seen.tx_type !== want.tx_type || seen.status !== want.status ||
            seen.awaiting !== want.awaiting || seen.queued !== want.queued) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: exp tx %0b seq %0d type 0x%02h st %0d aw %0b cnt %0d", $time,
                     want.tx_valid, want.tx_seq, want.tx_type, want.status,
                     want.awaiting, want.queued);
            $display("%0t: got tx %0b seq %0d type 0x%02h st %0d aw %0b cnt %0d", $time,
                     seen.tx_valid, seen.tx_seq, seen.tx_type, seen.status,
                     seen.awaiting, seen.queued);
          end
        end
      end
    end
  end

  initial begin
    logic [7:0] pong_sets[NUM_PHASES];
    logic [7:0] tile_sets[NUM_PHASES];

    pong_code = 8'd1;
    tile_code = 8'd2;
    seq_counter = '0;
    waiting = 1'b0;

    // extremes, swapped extremes, random, both codes equal, back to reset values
    pong_sets = '{8'd0, 8'd255, 8'd0, 8'd9, 8'd1};
    tile_sets = '{8'd255, 8'd0, 8'd0, 8'd9, 8'd2};
    pong_sets[2] = 8'($urandom_range(0, 255));
    tile_sets[2] = 8'($urandom_range(0, 255));

    // idle with nothing outstanding: unknown type, link down, empty confirm, no-op, reset
    add_row(OP_SEND, 8'h05, 2'd0, 1'b1, 1, 1, txrep(0, 0, 0, ST_UNKNOWN, 0, 0));
    add_row(OP_SEND, 8'h01, 2'd3, 1'b0, 1, 1, txrep(0, 0, 0, ST_DISCONNECTED, 0, 0));
    add_row(OP_CONFIRM, 8'hAA, 2'd2, 1'b0, 1, 1, txrep(0, 0, 0, ST_OK, 0, 0));
    add_row(OP_NOP, 8'hFF, 2'd3, 1'b1, 1, 1, txrep(0, 0, 0, ST_OK, 0, 0));
    add_row(OP_RESET, 8'h00, 2'd0, 1'b0, 1, 1, txrep(0, 0, 0, ST_OK, 0, 0));
    // pong goes straight out, then four are queued while waiting
    add_row(OP_SEND, 8'h01, 2'd3, 1'b1, 1, 1, txrep(1, 2, 8'h01, ST_OK, 1, 0));
    add_row(OP_SEND, 8'hFF, 2'd3, 1'b1, 1, 1, txrep(0, 0, 0, ST_QUEUED, 1, 1));
    add_row(OP_SEND, 8'h00, 2'd0, 1'b1, 1, 1, txrep(0, 0, 0, ST_QUEUED, 1, 2));
    add_row(OP_SEND, 8'h0D, 2'd3, 1'b1, 1, 1, txrep(0, 0, 0, ST_QUEUED, 1, 3));
    add_row(OP_SEND, 8'h25, 2'd0, 1'b1, 1, 1, txrep(0, 0, 0, ST_QUEUED, 1, 4));
    add_row(OP_SEND, 8'h02, 2'd1, 1'b0, 1, 1, txrep(0, 0, 0, ST_DISCONNECTED, 1, 4));
    // confirms drain by priority, oldest first among equals, whatever the type
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b1, 1, 1, txrep(1, 4, 8'h00, ST_OK, 1, 3));
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b0, 1, 1, txrep(1, 6, 8'h25, ST_OK, 1, 2));
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b1, 1, 1, txrep(1, 3, 8'hFF, ST_OK, 1, 1));
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b1, 1, 1, txrep(1, 5, 8'h0D, ST_OK, 1, 0));
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b1, 1, 1, txrep(0, 0, 0, ST_OK, 0, 0));
    // tile request out, fill the queue, overflow, then flush
    add_row(OP_SEND, 8'h02, 2'd2, 1'b1, 1, 1, txrep(1, 7, 8'h02, ST_OK, 1, 0));
    add_row(OP_SEND, 8'h80, 2'd1, 1'b1, HOLD_DEPTH, 0, '0);
    add_row(OP_SEND, 8'h01, 2'd0, 1'b1, 1, 1, txrep(0, 0, 0, ST_FULL, 1, 16));
    add_row(OP_CONFIRM, 8'h00, 2'd0, 1'b1, 1, 1, txrep(1, 8, 8'h80, ST_OK, 1, 15));
    add_row(OP_RESET, 8'hFF, 2'd3, 1'b1, 1, 1, txrep(0, 0, 0, ST_OK, 0, 0));
    add_row(OP_SEND, 8'h02, 2'd0, 1'b1, 1, 1, txrep(1, 25, 8'h02, ST_OK, 1, 0));
    add_row(OP_SEND, 8'h7E, 2'd2, 1'b1, 1, 0, '0);
    add_row(OP_SEND, 8'h33, 2'd1, 1'b1, 1, 0, '0);
    add_row(OP_CONFIRM, 8'h55, 2'd3, 1'b0, 1, 0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      repeat (directed_rows[i].reps) put_request(directed_rows[i]);

    // random phases, codes changed only while nothing is outstanding
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      s_tvalid <= 1'b0;
      while (tx_reports_due.size() != 0) @(posedge clk);
      @(posedge clk);
      program_type_code(REG_PONG, pong_sets[ph]);
      program_type_code(REG_TILE, tile_sets[ph]);
      if (ph == 1) hold_asks++;
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        put_request(random_request((ph % 2 == 0) ? 65 : 40));
    end

    s_tvalid <= 1'b0;
    while (tx_reports_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swps_pkg.sv
rtl/swps_cell.sv
rtl/swps_queue.sv
rtl/stop_and_wait_priority_sender_top.sv
verif/testbench.sv
